[hdl/jsu8_pkg.sv]
package jsu8_pkg;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_STR     = 3'd1,
        M_ESC     = 3'd2,
        M_HEX1    = 3'd3,
        M_WANT_BS = 3'd4,
        M_WANT_U  = 3'd5,
        M_HEX2    = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EXPECT_STR   = 3'd1,
        ST_BAD_ESCAPE   = 3'd2,
        ST_BAD_UNICODE  = 3'd3,
        ST_UNPAIRED     = 3'd4,
        ST_CONTROL      = 3'd5,
        ST_UNTERMINATED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        EMIT_NONE = 2'd0,
        EMIT_BYTE = 2'd1,
        EMIT_CP   = 2'd2
    } t_emit;

    // Decision taken for one input byte, handed from the next-state logic
    // to the result logic.
    typedef struct packed {
        logic    fin;
        t_status status;
        t_emit   emit;
        logic [7:0]  data;
        logic [20:0] cp;
    } t_decision;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [15:0] SURR_HI_LO = 16'hD800;
    localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
    localparam logic [15:0] SURR_LO_LO = 16'hDC00;
    localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
    localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

[hdl/json_string_unescape_utf8_top.sv]
// Streaming JSON string decoder.
// Slave channel (i_s_*): one raw text byte per request in i_s_tdata; i_s_tuser
// set means the text is exhausted and the data byte is ignored.
// Master channel (o_m_*): one result per request. o_m_tdata carries a decoded
// UTF-8 byte; o_m_tuser carries byte_valid, finished and the status code;
// o_m_tlast marks the final result caused by one input byte.
// Leading whitespace is skipped, an opening quote is required, escapes and
// \uXXXX surrogate pairs are decoded, and the string ends on the closing
// quote or on the first error, after which the block is idle again.
// An accepted byte is held in the input register and then decoded into the
// result buffer, from which its results are offered.
// Throughput: one input byte per cycle while each byte gives at most one
// result and the receiver is ready; a code point of more than one UTF-8
// byte holds the input while the single output port drains the buffer.
// A stalled receiver holds the result buffer; the input register then fills
// and o_s_tready drops until the buffer drains.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// decoder to idle, waiting for an opening quote.
module json_string_unescape_utf8_top
    import jsu8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic [0:0] i_s_tuser,   // [0] text_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [4:0] o_m_tuser,   // [0] byte_valid, [1] finished, [4:2] status
    output logic       o_m_tlast
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // Decoder state
    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_accum, n_code_accum;
    logic [15:0] r_high_half, n_high_half;

    // Result buffer
    logic [7:0] r_buf [4];
    logic [2:0] r_left;
    logic [1:0] r_idx;
    logic       r_fin;
    t_status    r_status;

    logic       buf_free;
    logic       adv;
    logic       pop;
    logic [4:0] hexv;
    logic [15:0] v;
    logic [9:0]  hi_off;
    t_decision   dec;

    logic [7:0] res_buf [4];
    logic [2:0] res_cnt;

    assign pop      = o_m_tvalid && i_m_tready;
    assign buf_free = (r_left == 3'd0) || ((r_left == 3'd1) && i_m_tready);
    assign adv      = r_in_valid && buf_free;
    assign o_s_tready = !r_in_valid || buf_free;

    assign hexv   = hex_value(r_in_byte);
    assign v      = {r_code_accum[11:0], hexv[3:0]};
    assign hi_off = (r_high_half < SURR_HI_LO) ? 10'd0 : r_high_half[9:0];

    // Next state and decision for the byte in the input register.
    always_comb begin
        n_mode       = r_mode;
        n_hex_count  = r_hex_count;
        n_code_accum = r_code_accum;
        n_high_half  = r_high_half;
        dec.fin      = 1'b0;
        dec.status   = ST_OK;
        dec.emit     = EMIT_NONE;
        dec.data     = r_in_byte;
        dec.cp       = {5'd0, v};
        case (r_mode)
            M_STR: begin
                if (r_in_end) begin
                    dec.fin = 1'b1; dec.status = ST_UNTERMINATED;
                end else if (r_in_byte == CH_QUOTE) begin
                    dec.fin = 1'b1; dec.status = ST_OK;
                end else if (r_in_byte == CH_BSL) begin
                    n_mode = M_ESC;
                end else if (r_in_byte < 8'h20) begin
                    dec.fin = 1'b1; dec.status = ST_CONTROL;
                end else begin
                    dec.emit = EMIT_BYTE;
                end
            end
            M_ESC: begin
                if (r_in_end) begin
                    dec.fin = 1'b1; dec.status = ST_BAD_ESCAPE;
                end else begin
                    n_mode   = M_STR;
                    dec.emit = EMIT_BYTE;
                    case (r_in_byte)
                        8'h22, 8'h5C, 8'h2F: dec.data = r_in_byte;
                        8'h62: dec.data = 8'h08;
                        8'h66: dec.data = 8'h0C;
                        8'h6E: dec.data = 8'h0A;
                        8'h72: dec.data = 8'h0D;
                        8'h74: dec.data = 8'h09;
                        8'h75: begin
                            dec.emit     = EMIT_NONE;
                            n_mode       = M_HEX1;
                            n_hex_count  = 2'd0;
                            n_code_accum = 16'd0;
                        end
                        default: begin
                            dec.emit = EMIT_NONE;
                            dec.fin = 1'b1; dec.status = ST_BAD_ESCAPE;
                        end
                    endcase
                end
            end
            M_HEX1, M_HEX2: begin
                if (r_in_end || !hexv[4]) begin
                    dec.fin = 1'b1; dec.status = ST_BAD_UNICODE;
                end else if (r_hex_count != 2'd3) begin
                    n_code_accum = v;
                    n_hex_count  = r_hex_count + 2'd1;
                end else begin
                    n_hex_count  = 2'd0;
                    n_code_accum = 16'd0;
                    if (r_mode == M_HEX1) begin
                        if (v >= SURR_HI_LO && v <= SURR_HI_HI) begin
                            n_high_half = v;
                            n_mode      = M_WANT_BS;
                        end else if (v >= SURR_LO_LO && v <= SURR_LO_HI) begin
                            dec.fin = 1'b1; dec.status = ST_UNPAIRED;
                        end else begin
                            n_mode   = M_STR;
                            dec.emit = EMIT_CP;
                        end
                    end else begin
                        if (v < SURR_LO_LO || v > SURR_LO_HI) begin
                            dec.fin = 1'b1; dec.status = ST_UNPAIRED;
                        end else begin
                            n_mode      = M_STR;
                            n_high_half = 16'd0;
                            dec.emit    = EMIT_CP;
                            dec.cp      = CP_SUPP_BASE + {1'b0, hi_off, v[9:0]};
                        end
                    end
                end
            end
            M_WANT_BS: begin
                if (r_in_end || r_in_byte != CH_BSL) begin
                    dec.fin = 1'b1; dec.status = ST_UNPAIRED;
                end else begin
                    n_mode = M_WANT_U;
                end
            end
            M_WANT_U: begin
                if (r_in_end || r_in_byte != CH_U) begin
                    dec.fin = 1'b1; dec.status = ST_UNPAIRED;
                end else begin
                    n_mode       = M_HEX2;
                    n_hex_count  = 2'd0;
                    n_code_accum = 16'd0;
                end
            end
            default: begin
                // Idle: skip whitespace, wait for the opening quote.
                if (r_in_end) begin
                    dec.fin = 1'b1; dec.status = ST_EXPECT_STR;
                end else if (r_in_byte == CH_QUOTE) begin
                    n_mode = M_STR;
                end else if (!(r_in_byte == 8'h20 || r_in_byte == 8'h09 ||
                               r_in_byte == 8'h0D || r_in_byte == 8'h0A)) begin
                    dec.fin = 1'b1; dec.status = ST_EXPECT_STR;
                end
            end
        endcase
        if (dec.fin) begin
            n_mode       = M_IDLE;
            n_hex_count  = 2'd0;
            n_code_accum = 16'd0;
            n_high_half  = 16'd0;
        end
    end

    // Result bytes for the decision, UTF-8 encoding of a code point.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            res_buf[i] = 8'd0;
        end
        res_cnt = 3'd0;
        if (dec.fin) begin
            res_cnt = 3'd1;
        end else if (dec.emit == EMIT_BYTE) begin
            res_cnt    = 3'd1;
            res_buf[0] = dec.data;
        end else if (dec.emit == EMIT_CP) begin
            if (dec.cp < 21'h80) begin
                res_cnt    = 3'd1;
                res_buf[0] = dec.cp[7:0];
            end else if (dec.cp < 21'h800) begin
                res_cnt    = 3'd2;
                res_buf[0] = {3'b110, dec.cp[10:6]};
                res_buf[1] = {2'b10, dec.cp[5:0]};
            end else if (dec.cp < 21'h10000) begin
                res_cnt    = 3'd3;
                res_buf[0] = {4'b1110, dec.cp[15:12]};
                res_buf[1] = {2'b10, dec.cp[11:6]};
                res_buf[2] = {2'b10, dec.cp[5:0]};
            end else begin
                res_cnt    = 3'd4;
                res_buf[0] = {5'b11110, dec.cp[20:18]};
                res_buf[1] = {2'b10, dec.cp[17:12]};
                res_buf[2] = {2'b10, dec.cp[11:6]};
                res_buf[3] = {2'b10, dec.cp[5:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_mode       <= M_IDLE;
            r_hex_count  <= 2'd0;
            r_code_accum <= 16'd0;
            r_high_half  <= 16'd0;
            r_left       <= 3'd0;
            r_idx        <= 2'd0;
            r_fin        <= 1'b0;
            r_status     <= ST_OK;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (adv) begin
                r_mode       <= n_mode;
                r_hex_count  <= n_hex_count;
                r_code_accum <= n_code_accum;
                r_high_half  <= n_high_half;
                r_left       <= res_cnt;
                r_idx        <= 2'd0;
                r_fin        <= dec.fin;
                r_status     <= dec.status;
            end else if (pop) begin
                r_left <= r_left - 3'd1;
                r_idx  <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_end  <= i_s_tuser[0];
        end
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                r_buf[i] <= res_buf[i];
            end
        end
    end

    assign o_m_tvalid = (r_left != 3'd0);
    assign o_m_tdata  = r_buf[r_idx];
    assign o_m_tuser  = {r_fin ? r_status : ST_OK, r_fin, !r_fin};
    assign o_m_tlast  = (r_left == 3'd1);

endmodule
